### hw/rtl/stf_pkg.sv
`timescale 1ns / 1ps
// stf_pkg: shared types and fixed-point constants of the single-axis tilt fusion unit
// depends on nothing; used by the interfaces and the top level

package stf_pkg;

   typedef logic [1:0] status_type;

   localparam status_type ST_FIRST   = 2'd0;
   localparam status_type ST_BAD_DT  = 2'd1;
   localparam status_type ST_GYRO    = 2'd2;
   localparam status_type ST_CORRECT = 2'd3;

   localparam logic [1:0] REG_GAIN_BETA   = 2'd0;
   localparam logic [1:0] REG_ACCEL_SCALE = 2'd1;
   localparam logic [1:0] REG_NORM_MIN    = 2'd2;
   localparam logic [1:0] REG_NORM_MAX    = 2'd3;

   localparam logic [15:0] GAIN_BETA_RST   = 16'd410;
   localparam logic [31:0] ACCEL_SCALE_RST = 32'd262144;
   localparam logic [15:0] NORM_MIN_RST    = 16'd3686;
   localparam logic [15:0] NORM_MAX_RST    = 16'd4506;

   localparam logic [31:0] MAX_DT_US = 32'd1000000;

   // angles in q5.27, widened for the reduction steps
   localparam logic signed [33:0] PI_Q27      = 34'sd421657428;
   localparam logic signed [33:0] TWO_PI_Q27  = 34'sd843314857;
   localparam logic signed [33:0] HALF_PI_Q27 = 34'sd210828714;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;

   // degrees to radians, q0.32
   localparam logic signed [27:0] DEG_TO_RAD_Q32 = 28'sd74961321;

   // microseconds times q.32 down to q.27
   localparam logic [25:0] DT_DIVISOR = 26'd32000000;

   function automatic logic signed [33:0] atan_entry(input logic [4:0] idx);
      logic signed [33:0] v;
      case (idx)
         5'd0:  v = 34'sd843314857;
         5'd1:  v = 34'sd497837829;
         5'd2:  v = 34'sd263043837;
         5'd3:  v = 34'sd133525159;
         5'd4:  v = 34'sd67021687;
         5'd5:  v = 34'sd33543516;
         5'd6:  v = 34'sd16775851;
         5'd7:  v = 34'sd8388437;
         5'd8:  v = 34'sd4194283;
         5'd9:  v = 34'sd2097149;
         5'd10: v = 34'sd1048576;
         5'd11: v = 34'sd524288;
         5'd12: v = 34'sd262144;
         5'd13: v = 34'sd131072;
         5'd14: v = 34'sd65536;
         5'd15: v = 34'sd32768;
         5'd16: v = 34'sd16384;
         5'd17: v = 34'sd8192;
         5'd18: v = 34'sd4096;
         5'd19: v = 34'sd2048;
         5'd20: v = 34'sd1024;
         5'd21: v = 34'sd512;
         5'd22: v = 34'sd256;
         5'd23: v = 34'sd128;
         5'd24: v = 34'sd64;
         5'd25: v = 34'sd32;
         5'd26: v = 34'sd16;
         5'd27: v = 34'sd8;
         5'd28: v = 34'sd4;
         5'd29: v = 34'sd2;
         5'd30: v = 34'sd1;
         default: v = 34'sd0;
      endcase
      return v;
   endfunction

endpackage

### hw/rtl/stf_if.sv
`timescale 1ns / 1ps
// stf_req_if, stf_rsp_if: valid/ready channels of the tilt fusion unit
// depends on stf_pkg

interface stf_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [31:0] gyro_rate;
   logic        [31:0] time_us;

   modport source (output valid, accel_x, accel_y, gyro_rate, time_us, input ready);
   modport sink   (input valid, accel_x, accel_y, gyro_rate, time_us, output ready);
endinterface

interface stf_rsp_if;
   logic                 valid;
   logic                 ready;
   logic signed [31:0]   tilt_angle;
   stf_pkg::status_type  status;

   modport source (output valid, tilt_angle, status, input ready);
   modport sink   (input valid, tilt_angle, status, output ready);
endinterface

### hw/rtl/single_axis_tilt_fusion_unit.sv
`timescale 1ns / 1ps
// single_axis_tilt_fusion_unit: one-axis gyro/accelerometer tilt estimator
// depends on stf_pkg and stf_if (stf_req_if, stf_rsp_if)
//
// usage
//   req carries one imu sample per transfer: raw accel x/y, gyro z rate
//   (q16.16 deg/s) and a microsecond timestamp. rsp returns one transfer per
//   sample: the tilt angle (q5.27 rad, saturating) and a status code.
//   csr_we/csr_index/csr_wdata write gain, accel scale and the norm window;
//   write them only while the unit is idle.
// sequence
//   one sample at a time. a first sample or a bad interval goes straight to
//   the result register; a gyro-only update runs the bit-serial square root
//   (32 steps) and the divide by 32e6 (67 steps); a corrected one adds the two
//   unit vector dividers (62 steps, skipped for a zero norm), the full-turn
//   reduction (up to 3 steps) and CORDIC_STEPS rotations. req.ready returns
//   as the result register loads.
// reset
//   synchronous, active high: angle and stored time go to zero (no previous
//   sample) and the registers take their default values.
// stalls
//   a finished result sits in the output register; req.ready rises again at
//   once, and the next result waits until rsp is taken

module single_axis_tilt_fusion_unit #(
   parameter int unsigned CORDIC_STEPS = 24
) (
   input  logic        clock,
   input  logic        reset,
   stf_req_if.sink     req,
   stf_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SCALE = 4'd1;
   localparam logic [3:0] S_SQA   = 4'd2;
   localparam logic [3:0] S_SQB   = 4'd3;
   localparam logic [3:0] S_SQRT  = 4'd4;
   localparam logic [3:0] S_CHK   = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_RED   = 4'd7;
   localparam logic [3:0] S_CORD  = 4'd8;
   localparam logic [3:0] S_MULA  = 4'd9;
   localparam logic [3:0] S_MULB  = 4'd10;
   localparam logic [3:0] S_GRAD  = 4'd11;
   localparam logic [3:0] S_BETA  = 4'd12;
   localparam logic [3:0] S_RATE  = 4'd13;
   localparam logic [3:0] S_KDIV  = 4'd14;
   localparam logic [3:0] S_DONE  = 4'd15;

   localparam logic [6:0] CORD_LAST = 7'(CORDIC_STEPS - 1);
   localparam logic [6:0] SQRT_LAST = 7'd31;
   localparam logic [6:0] DIV_LAST  = 7'd61;
   localparam logic [6:0] KDIV_LAST = 7'd66;

   // control state
   logic [3:0]  state_ff, state_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] angle_ff, angle_in;
   logic [31:0] last_time_ff, last_time_in;
   logic [15:0] beta_ff, beta_in;
   logic [31:0] scale_ff, scale_in;
   logic [15:0] nmin_ff, nmin_in;
   logic [15:0] nmax_ff, nmax_in;

   // datapath
   stf_pkg::status_type status_ff, status_in;
   stf_pkg::status_type rsp_status_ff, rsp_status_in;
   logic signed [31:0] rsp_angle_ff, rsp_angle_in;
   logic signed [15:0] ax_ff, ax_in, ay_ff, ay_in;
   logic signed [31:0] gyro_ff, gyro_in;
   logic [19:0] dt_ff, dt_in;
   logic [31:0] axm_ff, axm_in, aym_ff, aym_in;
   logic [63:0] sq_ff, sq_in;
   logic [34:0] srem_ff, srem_in;
   logic [31:0] root_ff, root_in;
   logic [61:0] dvx_ff, dvx_in, dvy_ff, dvy_in;
   logic [32:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [31:0] qx_ff, qx_in, qy_ff, qy_in;
   logic signed [33:0] ang_ff, ang_in;
   logic        neg_ff, neg_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic signed [65:0] pa_ff, pa_in, pb_ff, pb_in;
   logic signed [36:0] grad_ff, grad_in;
   logic signed [55:0] rate_ff, rate_in;
   logic [66:0] prod_ff, prod_in;
   logic        pneg_ff, pneg_in;
   logic [25:0] krem_ff, krem_in;
   logic [44:0] kq_ff, kq_in;

   // combinational helpers
   logic [31:0] dt_full;
   logic [15:0] ax_abs, ay_abs;
   logic [47:0] axs_full, ays_full;
   logic signed [59:0] gyro_prod;
   logic [34:0] srem_sh, srem_trial;
   logic [32:0] rx_sh, ry_sh;
   logic signed [31:0] ux_w, uy_w;
   logic signed [33:0] cos_w, sin_w, cdx, cdy, catan;
   logic signed [66:0] grad_diff;
   logic signed [53:0] beta_prod;
   logic signed [45:0] rate32;
   logic signed [66:0] dt_prod;
   logic [25:0] krem_sh;
   logic signed [46:0] delta_w, sum_w;

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.tilt_angle = rsp_angle_ff;
   assign rsp.status = rsp_status_ff;

   always_comb begin
      dt_full   = req.time_us - last_time_ff;
      ax_abs    = ax_ff[15] ? 16'(-ax_ff) : ax_ff;
      ay_abs    = ay_ff[15] ? 16'(-ay_ff) : ay_ff;
      axs_full  = 48'(ax_abs) * 48'(scale_ff);
      ays_full  = 48'(ay_abs) * 48'(scale_ff);
      gyro_prod = $signed(gyro_ff) * $signed(stf_pkg::DEG_TO_RAD_Q32);
      srem_sh   = {srem_ff[32:0], sq_ff[63:62]};
      srem_trial = {1'b0, root_ff, 2'b01};
      rx_sh     = {rx_ff[31:0], dvx_ff[61]};
      ry_sh     = {ry_ff[31:0], dvy_ff[61]};
      // unit vector, sign restored; zero when the norm was zero
      ux_w = ax_ff[15] ? -$signed(qx_ff) : $signed(qx_ff);
      uy_w = ay_ff[15] ? -$signed(qy_ff) : $signed(qy_ff);
      cos_w = neg_ff ? -cx_ff : cx_ff;
      sin_w = neg_ff ? -cy_ff : cy_ff;
      cdx   = cy_ff >>> cnt_ff[4:0];
      cdy   = cx_ff >>> cnt_ff[4:0];
      catan = stf_pkg::atan_entry(cnt_ff[4:0]);
      grad_diff = {pa_ff[65], pa_ff} - {pb_ff[65], pb_ff};
      beta_prod = $signed({1'b0, beta_ff}) * grad_ff;
      rate32    = rate_ff[55:10];
      dt_prod   = rate32 * $signed({1'b0, dt_ff});
      krem_sh   = {krem_ff[24:0], prod_ff[66]};
      delta_w   = pneg_ff ? -$signed({2'b00, kq_ff}) : $signed({2'b00, kq_ff});
      sum_w     = {{15{angle_ff[31]}}, angle_ff} + delta_w;
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      angle_in      = angle_ff;
      last_time_in  = last_time_ff;
      beta_in       = beta_ff;
      scale_in      = scale_ff;
      nmin_in       = nmin_ff;
      nmax_in       = nmax_ff;
      status_in     = status_ff;
      rsp_status_in = rsp_status_ff;
      rsp_angle_in  = rsp_angle_ff;
      ax_in   = ax_ff;
      ay_in   = ay_ff;
      gyro_in = gyro_ff;
      dt_in   = dt_ff;
      axm_in  = axm_ff;
      aym_in  = aym_ff;
      sq_in   = sq_ff;
      srem_in = srem_ff;
      root_in = root_ff;
      dvx_in  = dvx_ff;
      dvy_in  = dvy_ff;
      rx_in   = rx_ff;
      ry_in   = ry_ff;
      qx_in   = qx_ff;
      qy_in   = qy_ff;
      ang_in  = ang_ff;
      neg_in  = neg_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      cz_in   = cz_ff;
      pa_in   = pa_ff;
      pb_in   = pb_ff;
      grad_in = grad_ff;
      rate_in = rate_ff;
      prod_in = prod_ff;
      pneg_in = pneg_ff;
      krem_in = krem_ff;
      kq_in   = kq_ff;

      // register writes
      if (csr_we) begin
         case (csr_index)
            stf_pkg::REG_GAIN_BETA:   beta_in  = csr_wdata[15:0];
            stf_pkg::REG_ACCEL_SCALE: scale_in = csr_wdata;
            stf_pkg::REG_NORM_MIN:    nmin_in  = csr_wdata[15:0];
            stf_pkg::REG_NORM_MAX:    nmax_in  = csr_wdata[15:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               ax_in        = req.accel_x;
               ay_in        = req.accel_y;
               gyro_in      = req.gyro_rate;
               dt_in        = dt_full[19:0];
               last_time_in = req.time_us;
               if (last_time_ff == 32'd0) begin
                  status_in = stf_pkg::ST_FIRST;
                  state_in  = S_DONE;
               end else if (dt_full == 32'd0 || dt_full > stf_pkg::MAX_DT_US) begin
                  status_in = stf_pkg::ST_BAD_DT;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_SCALE;
               end
            end
         end
         S_SCALE: begin
            axm_in   = axs_full[47:16];
            aym_in   = ays_full[47:16];
            rate_in  = {{2{gyro_prod[59]}}, gyro_prod[59:6]};
            state_in = S_SQA;
         end
         S_SQA: begin
            sq_in    = 64'(axm_ff) * 64'(axm_ff);
            state_in = S_SQB;
         end
         S_SQB: begin
            sq_in    = sq_ff + 64'(aym_ff) * 64'(aym_ff);
            srem_in  = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            // two radicand bits per step
            if (srem_sh >= srem_trial) begin
               srem_in = srem_sh - srem_trial;
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               srem_in = srem_sh;
               root_in = {root_ff[30:0], 1'b0};
            end
            sq_in  = {sq_ff[61:0], 2'b00};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == SQRT_LAST) begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            cnt_in = '0;
            rx_in  = '0;
            ry_in  = '0;
            qx_in  = '0;
            qy_in  = '0;
            dvx_in = {axm_ff, 30'd0};
            dvy_in = {aym_ff, 30'd0};
            ang_in = {{2{angle_ff[31]}}, angle_ff};
            if ({4'd0, root_ff} >= {16'd0, nmin_ff, 4'd0} &&
                {4'd0, root_ff} <= {16'd0, nmax_ff, 4'd0}) begin
               status_in = stf_pkg::ST_CORRECT;
               // zero norm gives a zero unit vector
               state_in  = (root_ff == 32'd0) ? S_RED : S_DIV;
            end else begin
               status_in = stf_pkg::ST_GYRO;
               state_in  = S_RATE;
            end
         end
         S_DIV: begin
            if (rx_sh >= {1'b0, root_ff}) begin
               rx_in = rx_sh - {1'b0, root_ff};
               qx_in = {qx_ff[30:0], 1'b1};
            end else begin
               rx_in = rx_sh;
               qx_in = {qx_ff[30:0], 1'b0};
            end
            if (ry_sh >= {1'b0, root_ff}) begin
               ry_in = ry_sh - {1'b0, root_ff};
               qy_in = {qy_ff[30:0], 1'b1};
            end else begin
               ry_in = ry_sh;
               qy_in = {qy_ff[30:0], 1'b0};
            end
            dvx_in = {dvx_ff[60:0], 1'b0};
            dvy_in = {dvy_ff[60:0], 1'b0};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_RED;
            end
         end
         S_RED: begin
            // full turns first, then the half-turn fold
            if (ang_ff > stf_pkg::PI_Q27) begin
               ang_in = ang_ff - stf_pkg::TWO_PI_Q27;
            end else if (ang_ff < -stf_pkg::PI_Q27) begin
               ang_in = ang_ff + stf_pkg::TWO_PI_Q27;
            end else begin
               cnt_in   = '0;
               cx_in    = stf_pkg::CORDIC_GAIN;
               cy_in    = '0;
               state_in = S_CORD;
               if (ang_ff > stf_pkg::HALF_PI_Q27) begin
                  cz_in  = (ang_ff - stf_pkg::PI_Q27) <<< 3;
                  neg_in = 1'b1;
               end else if (ang_ff < -stf_pkg::HALF_PI_Q27) begin
                  cz_in  = (ang_ff + stf_pkg::PI_Q27) <<< 3;
                  neg_in = 1'b1;
               end else begin
                  cz_in  = ang_ff <<< 3;
                  neg_in = 1'b0;
               end
            end
         end
         S_CORD: begin
            if (!cz_ff[33]) begin
               cx_in = cx_ff - cdx;
               cy_in = cy_ff + cdy;
               cz_in = cz_ff - catan;
            end else begin
               cx_in = cx_ff + cdx;
               cy_in = cy_ff - cdy;
               cz_in = cz_ff + catan;
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == CORD_LAST) begin
               state_in = S_MULA;
            end
         end
         S_MULA: begin
            pa_in    = uy_w * cos_w;
            state_in = S_MULB;
         end
         S_MULB: begin
            pb_in    = ux_w * sin_w;
            state_in = S_GRAD;
         end
         S_GRAD: begin
            grad_in  = grad_diff[66:30];
            state_in = S_BETA;
         end
         S_BETA: begin
            rate_in  = rate_ff - {{2{beta_prod[53]}}, beta_prod};
            state_in = S_RATE;
         end
         S_RATE: begin
            pneg_in  = dt_prod[66];
            prod_in  = dt_prod[66] ? 67'(-dt_prod) : 67'(dt_prod);
            krem_in  = '0;
            kq_in    = '0;
            cnt_in   = '0;
            state_in = S_KDIV;
         end
         S_KDIV: begin
            if (krem_sh >= stf_pkg::DT_DIVISOR) begin
               krem_in = krem_sh - stf_pkg::DT_DIVISOR;
               kq_in   = {kq_ff[43:0], 1'b1};
            end else begin
               krem_in = krem_sh;
               kq_in   = {kq_ff[43:0], 1'b0};
            end
            prod_in = {prod_ff[65:0], 1'b0};
            cnt_in  = cnt_ff + 7'd1;
            if (cnt_ff == KDIV_LAST) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // fold the quotient into the angle on the way out
            if (!rsp_valid_ff || rsp.ready) begin
               if (status_ff == stf_pkg::ST_GYRO || status_ff == stf_pkg::ST_CORRECT) begin
                  if (sum_w > 47'sd2147483647) begin
                     angle_in = 32'sh7fffffff;
                  end else if (sum_w < -47'sd2147483648) begin
                     angle_in = 32'sh80000000;
                  end else begin
                     angle_in = sum_w[31:0];
                  end
               end
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_angle_in  = angle_in;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         angle_ff     <= '0;
         last_time_ff <= '0;
         beta_ff      <= stf_pkg::GAIN_BETA_RST;
         scale_ff     <= stf_pkg::ACCEL_SCALE_RST;
         nmin_ff      <= stf_pkg::NORM_MIN_RST;
         nmax_ff      <= stf_pkg::NORM_MAX_RST;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         angle_ff     <= angle_in;
         last_time_ff <= last_time_in;
         beta_ff      <= beta_in;
         scale_ff     <= scale_in;
         nmin_ff      <= nmin_in;
         nmax_ff      <= nmax_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_angle_ff  <= rsp_angle_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      gyro_ff <= gyro_in;
      dt_ff   <= dt_in;
      axm_ff  <= axm_in;
      aym_ff  <= aym_in;
      sq_ff   <= sq_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      dvx_ff  <= dvx_in;
      dvy_ff  <= dvy_in;
      rx_ff   <= rx_in;
      ry_ff   <= ry_in;
      qx_ff   <= qx_in;
      qy_ff   <= qy_in;
      ang_ff  <= ang_in;
      neg_ff  <= neg_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      grad_ff <= grad_in;
      rate_ff <= rate_in;
      prod_ff <= prod_in;
      pneg_ff <= pneg_in;
      krem_ff <= krem_in;
      kq_ff   <= kq_in;
   end

endmodule

### tb/sv/tb_single_axis_tilt_fusion_unit.sv
`timescale 1ns / 1ps
// testbench of single_axis_tilt_fusion_unit: random and directed imu samples, an
// integer tilt predictor and a scoreboard of expected angle and status per transfer
// depends on stf_pkg, stf_if and the unit itself

class tilt_scoreboard;
   // register copies and filter state
   logic [15:0] beta;
   logic [31:0] scale;
   logic [15:0] nmin;
   logic [15:0] nmax;
   logic signed [31:0] angle_q27;
   logic [31:0] prev_time;
   logic signed [31:0] exp_angle[$];
   stf_pkg::status_type exp_status[$];
   int errors;

   function new();
      beta = stf_pkg::GAIN_BETA_RST;
      scale = stf_pkg::ACCEL_SCALE_RST;
      nmin = stf_pkg::NORM_MIN_RST;
      nmax = stf_pkg::NORM_MAX_RST;
      angle_q27 = 0;
      prev_time = 0;
      errors = 0;
   endfunction

   function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
         stf_pkg::REG_GAIN_BETA:   beta = val[15:0];
         stf_pkg::REG_ACCEL_SCALE: scale = val;
         stf_pkg::REG_NORM_MIN:    nmin = val[15:0];
         default:                  nmax = val[15:0];
      endcase
   endfunction

   // arithmetic shift is a floor shift
   function longint fshr(longint v, int s);
      return v >>> s;
   endfunction

   function longint scaled_g(logic signed [15:0] raw);
      longint v;
      longint m;
      v = raw;
      m = ((v < 0 ? -v : v) * longint'({32'd0, scale})) >> 16;
      return v < 0 ? -m : m;
   endfunction

   function longint int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function longint unit_q30(longint a, longint n);
      longint m;
      if (n == 0) return 0;
      m = ((a < 0 ? -a : a) << 30) / n;
      return a < 0 ? -m : m;
   endfunction

   function void sin_cos(longint a, output longint s, output longint c);
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      bit flip;
      x = stf_pkg::CORDIC_GAIN;
      y = 0;
      flip = 0;
      while (a > stf_pkg::PI_Q27) a -= stf_pkg::TWO_PI_Q27;
      while (a < -stf_pkg::PI_Q27) a += stf_pkg::TWO_PI_Q27;
      if (a > stf_pkg::HALF_PI_Q27) begin
         a -= stf_pkg::PI_Q27;
         flip = 1;
      end else if (a < -stf_pkg::HALF_PI_Q27) begin
         a += stf_pkg::PI_Q27;
         flip = 1;
      end
      z = a * 8;
      for (int i = 0; i < 24; i++) begin
         dx = fshr(y, i);
         dy = fshr(x, i);
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= stf_pkg::atan_entry(i[4:0]);
         end else begin
            x += dx;
            y -= dy;
            z += stf_pkg::atan_entry(i[4:0]);
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function void note_sample(logic signed [15:0] ax_raw, logic signed [15:0] ay_raw,
                             logic signed [31:0] gyro, logic [31:0] now);
      logic [31:0] dt;
      stf_pkg::status_type st;
      longint ax, ay, norm, rate, ux, uy, s, c, grad, delta, sum;
      if (prev_time == 0) begin
         st = stf_pkg::ST_FIRST;
      end else begin
         dt = now - prev_time;
         if (dt == 0 || dt > stf_pkg::MAX_DT_US) begin
            st = stf_pkg::ST_BAD_DT;
         end else begin
            ax = scaled_g(ax_raw);
            ay = scaled_g(ay_raw);
            norm = int_sqrt(longint'(ax * ax) + longint'(ay * ay));
            rate = fshr(longint'(gyro) * stf_pkg::DEG_TO_RAD_Q32, 6);
            st = stf_pkg::ST_GYRO;
            if (norm >= longint'(nmin) * 16 && norm <= longint'(nmax) * 16) begin
               ux = unit_q30(ax, norm);
               uy = unit_q30(ay, norm);
               sin_cos(angle_q27, s, c);
               grad = fshr(uy * c - ux * s, 30);
               rate -= longint'(beta) * grad;
               st = stf_pkg::ST_CORRECT;
            end
            // division truncates toward zero
            delta = fshr(rate, 10) * longint'({32'd0, dt}) / 64'sd32000000;
            sum = longint'(angle_q27) + delta;
            if (sum > 64'sd2147483647) sum = 64'sd2147483647;
            if (sum < -64'sd2147483648) sum = -64'sd2147483648;
            angle_q27 = sum[31:0];
         end
      end
      prev_time = now;
      exp_angle.push_back(angle_q27);
      exp_status.push_back(st);
   endfunction

   function void check_result(logic signed [31:0] ang, stf_pkg::status_type st);
      if (exp_angle.size() == 0) begin
         $error("result with nothing expected: tilt_angle %0d status %0d", ang, st);
         errors++;
         return;
      end
      if (ang !== exp_angle[0]) begin
         $error("tilt_angle expected %0d actual %0d", exp_angle[0], ang);
         errors++;
      end
      if (st !== exp_status[0]) begin
         $error("status expected %0d actual %0d", exp_status[0], st);
         errors++;
      end
      void'(exp_angle.pop_front());
      void'(exp_status.pop_front());
   endfunction
endclass

module tb_single_axis_tilt_fusion_unit;

   logic clock;
   logic reset;
   logic csr_we;
   logic [1:0] csr_index;
   logic [31:0] csr_wdata;

   stf_req_if req ();
   stf_rsp_if rsp ();

   single_axis_tilt_fusion_unit dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   tilt_scoreboard board;
   int idle_pct_tx;      // sender idling chance in percent
   int idle_pct_rx;      // receiver idling chance
   int hold_off;         // receiver stall length asked by stimulus
   int quiet_cycles;     // cycles with no transfer, for the watchdog
   logic [31:0] clock_us;  // running timestamp for well-formed sequences

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // result side: random back-pressure plus an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_off > 0) begin
         rsp.ready <= 1'b0;
         hold_off <= hold_off - 1;
      end else begin
         rsp.ready <= ($urandom_range(99) >= idle_pct_rx);
      end
      if (!reset && rsp.valid && rsp.ready) board.check_result(rsp.tilt_angle, rsp.status);
   end

   // watchdog: fails the run when quiet_cycles passes its limit with no transfer
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // one sample transfer, with random idle cycles ahead of it
   task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [31:0] gz, logic [31:0] t);
      while ($urandom_range(99) < idle_pct_tx) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.accel_x <= ax;
      req.accel_y <= ay;
      req.gyro_rate <= gz;
      req.time_us <= t;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      board.note_sample(ax, ay, gz, t);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (board.exp_angle.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      board.write_reg(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // raw accel within +-1 g half the time for the default scale, else any value, so some samples get corrected
   function automatic logic signed [15:0] accel_near_g();
      return $urandom_range(1) ? 16'($urandom_range(32768) - 16384)
                               : 16'($urandom_range(65535));
   endfunction

   // mostly well-formed timing, sometimes a bad interval or a zero stamp
   task automatic random_sample();
      int pick;
      logic [31:0] t;
      pick = $urandom_range(99);
      if (pick < 80) clock_us = clock_us + $urandom_range(1000000, 1);
      else if (pick < 88) clock_us = clock_us + 1000000 + $urandom_range(4000000);
      else if (pick < 92) clock_us = clock_us;
      else if (pick < 94) clock_us = 0;
      else clock_us = $urandom;
      t = clock_us;
      send_sample(accel_near_g(), accel_near_g(),
                  $urandom_range(1) ? $urandom : 32'($urandom_range(200 << 16)) - (100 << 16), t);
   endtask

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) begin
         if (i == n / 3) begin
            idle_pct_tx = 0;
            idle_pct_rx = 0;
         end
         if (i == n / 3 + 60) begin
            idle_pct_tx = 32;
            idle_pct_rx = 32;
         end
         random_sample();
      end
      idle_pct_tx = 32;
      idle_pct_rx = 32;
   endtask

   initial begin
      board = new();
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = stf_pkg::REG_GAIN_BETA;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.accel_x = '0;
      req.accel_y = '0;
      req.gyro_rate = '0;
      req.time_us = '0;
      hold_off = 0;
      idle_pct_tx = 32;
      idle_pct_rx = 32;
      clock_us = 32'd1000;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: first sample, bad intervals, extremes, saturation, wrap
      send_sample(16'sd0, 16'sd4096, 32'sd0, 32'd0);            // zero stamp, first
      send_sample(16'sd0, 16'sd4096, 32'sd0, 32'd100);          // first again
      send_sample(16'sd0, 16'sd4096, 32'sd0, 32'd100);          // zero interval
      send_sample(16'sd0, 16'sd4096, 32'sd0, 32'd1000101);      // over one second
      send_sample(16'sd0, 16'sd16384, 32'sd655360, 32'd1000200); // corrected
      send_sample(16'sd16384, 16'sd0, 32'sd655360, 32'd2000200); // exactly one second
      send_sample(-16'sd32768, 16'sd32767, 32'h7fffffff, 32'd2000201);
      send_sample(16'sd32767, -16'sd32768, 32'h80000000, 32'd2001201);
      send_sample(16'sd0, 16'sd0, 32'h7fffffff, 32'd2501201);   // gyro only
      for (int i = 0; i < 6; i++)                               // drive into saturation
         send_sample(16'sd0, 16'sd0, 32'h7fffffff, 32'd3001201 + i * 1000000);
      for (int i = 0; i < 6; i++)
         send_sample(16'sd0, 16'sd0, 32'h80000000, 32'd9001201 + i * 1000000);
      send_sample(16'sd100, -16'sd100, 32'sd1, 32'hffffff00);
      send_sample(16'sd100, -16'sd100, 32'sd1, 32'h00000050);   // wrapping interval
      drain();
      clock_us = 32'h00000050;

      // default registers
      random_phase(250);

      // receiver holds off long while the sender keeps offering
      hold_off = 3000;
      random_phase(40);
      drain();

      // zero norm admitted, maximum gain, full scale
      write_csr(stf_pkg::REG_NORM_MIN, 32'd0);
      write_csr(stf_pkg::REG_GAIN_BETA, 32'hffff);
      write_csr(stf_pkg::REG_ACCEL_SCALE, 32'hffffffff);
      write_csr(stf_pkg::REG_NORM_MAX, 32'hffff);
      send_sample(16'sd0, 16'sd0, 32'sd65536, clock_us + 10);
      clock_us = clock_us + 10;
      random_phase(200);
      drain();

      // inverted window never corrects
      write_csr(stf_pkg::REG_NORM_MIN, 32'hffff);
      write_csr(stf_pkg::REG_NORM_MAX, 32'd0);
      write_csr(stf_pkg::REG_GAIN_BETA, 32'd0);
      write_csr(stf_pkg::REG_ACCEL_SCALE, 32'd0);
      random_phase(150);
      drain();

      // mid settings with random bits in every register
      write_csr(stf_pkg::REG_GAIN_BETA, $urandom);
      write_csr(stf_pkg::REG_ACCEL_SCALE, 32'd262144 + $urandom_range(65535));
      write_csr(stf_pkg::REG_NORM_MIN, 32'd2000 + $urandom_range(1000));
      write_csr(stf_pkg::REG_NORM_MAX, 32'd5000 + $urandom_range(60000));
      random_phase(200);
      drain();

      write_csr(stf_pkg::REG_GAIN_BETA, stf_pkg::GAIN_BETA_RST);
      write_csr(stf_pkg::REG_ACCEL_SCALE, $urandom);
      write_csr(stf_pkg::REG_NORM_MIN, stf_pkg::NORM_MIN_RST);
      write_csr(stf_pkg::REG_NORM_MAX, stf_pkg::NORM_MAX_RST);
      random_phase(250);

      drain();
      if (board.errors == 0 && board.exp_angle.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
